// File: rtl/mcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_pkg
// Types, constants and lookup functions shared by the command framer modules.
// ----------------------------------------------------------------------------
package mcf_pkg;

   localparam int PACKET_BYTES = 17;
   localparam int IDX_W        = $clog2(PACKET_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

   // Command modes.
   localparam logic [2:0] MODE_RES    = 3'd0;
   localparam logic [2:0] MODE_RATE   = 3'd1;
   localparam logic [2:0] MODE_DEB    = 3'd2;
   localparam logic [2:0] MODE_BTN    = 3'd3;
   localparam logic [2:0] MODE_COMMIT = 3'd4;
   localparam logic [2:0] MODE_FW     = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_VALUE  = 2'd1;
   localparam logic [1:0] ST_BAD_ACTION = 2'd2;

   // Button action kinds.
   localparam logic [1:0] KIND_DISABLE = 2'd0;
   localparam logic [1:0] KIND_BUTTON  = 2'd1;

   // Fixed report bytes.
   localparam logic [7:0] FRAME_TAG      = 8'h08;
   localparam logic [7:0] SUM_TARGET     = 8'h55;
   localparam logic [7:0] OP_SET         = 8'h07;
   localparam logic [7:0] OP_COMMIT      = 8'h02;
   localparam logic [7:0] OP_FW          = 8'h01;
   localparam logic [7:0] RES_SUBHDR     = 8'h0c;
   localparam logic [7:0] DEB_SUBHDR     = 8'ha9;
   localparam logic [7:0] RES_TRAILER    = 8'he1;
   localparam logic [7:0] RATE_TRAILER   = 8'hef;
   localparam logic [7:0] DEB_TRAILER    = 8'h46;
   localparam logic [7:0] LEN_FOUR       = 8'h04;
   localparam logic [7:0] LEN_TWO        = 8'h02;
   localparam logic [7:0] LEN_ONE        = 8'h01;
   localparam logic [7:0] LEN_EIGHT      = 8'h08;

   // Resolution range and the reciprocal used to divide by the step of 50.
   localparam logic [15:0] RES_MIN     = 16'd50;
   localparam logic [15:0] RES_MAX     = 16'd12800;
   localparam int          RES_RECIP   = 20972;
   localparam int          RECIP_SHIFT = 20;
   localparam int          QUOT_W      = 9;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] value;
      logic [2:0]  button_slot;
      logic [1:0]  action_kind;
      logic [3:0]  target_button;
   } mcf_req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
      logic [1:0] status;
   } mcf_rsp_type;

   // Classified command: the bytes that vary, already with the checksum in place.
   typedef struct packed {
      logic       is_err;
      logic [1:0] status;
      logic [7:0] b1;
      logic [7:0] b4;
      logic [7:0] b5;
      logic [7:0] b6;
      logic [7:0] b7;
      logic [7:0] b9;
      logic [7:0] b16;
   } mcf_desc_type;

   // Report rate code; zero marks a rate that cannot be encoded.
   function automatic logic [7:0] rate_code(input logic [15:0] hz);
      logic [7:0] code;
      case (hz)
         16'd4:    code = 8'd250;
         16'd5:    code = 8'd200;
         16'd8:    code = 8'd125;
         16'd10:   code = 8'd100;
         16'd20:   code = 8'd50;
         16'd25:   code = 8'd40;
         16'd40:   code = 8'd25;
         16'd50:   code = 8'd20;
         16'd100:  code = 8'd10;
         16'd125:  code = 8'd8;
         16'd200:  code = 8'd5;
         16'd250:  code = 8'd4;
         16'd500:  code = 8'd2;
         16'd1000: code = 8'd1;
         default:  code = 8'd0;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] button_code(input logic [3:0] target);
      logic [7:0] code;
      case (target)
         4'd1:    code = 8'h60;
         4'd2:    code = 8'h64;
         4'd3:    code = 8'h68;
         4'd4:    code = 8'h70;
         4'd5:    code = 8'h6c;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// File: rtl/mcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_front
// Accepts commands, validates them and builds the report descriptor.
// ----------------------------------------------------------------------------
module mcf_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   output logic                  req_full,
   input  mcf_pkg::mcf_req_type  req_data,
   output logic                  desc_valid,
   input  wire                   desc_full,
   output mcf_pkg::mcf_desc_type desc_data
);
   import mcf_pkg::*;

   localparam logic [1:0] CS_AT_7  = 2'd0;
   localparam logic [1:0] CS_AT_9  = 2'd1;
   localparam logic [1:0] CS_AT_16 = 2'd2;

   logic                  valid_ff, valid_in;
   mcf_req_type           cmd_ff;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic                  in_range_ff, in_range_in;
   logic [28:0]           product;
   logic                  accept;
   logic                  advance;

   logic [14:0]           quot_x50;
   logic [7:0]            rate_raw;
   logic [7:0]            mask;
   logic [7:0]            en;
   logic [7:0]            byte_sum;
   logic [7:0]            cs;
   logic [1:0]            cs_sel;
   mcf_desc_type          desc;

   assign advance  = valid_ff && !desc_full;
   assign req_full = valid_ff && desc_full;
   assign accept   = req_push && !req_full;

   // Divide by 50 through the reciprocal; exact for every value up to 12800.
   assign product     = 29'(req_data.value[13:0]) * 29'(RES_RECIP);
   assign quot_in     = product[RECIP_SHIFT +: QUOT_W];
   assign in_range_in = (req_data.value >= RES_MIN) && (req_data.value <= RES_MAX);

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_data;
         quot_ff     <= quot_in;
         in_range_ff <= in_range_in;
      end
   end

   assign quot_x50 = {1'b0, quot_ff, 5'b0} + {2'b0, quot_ff, 4'b0} + {5'b0, quot_ff, 1'b0};
   assign rate_raw = rate_code(cmd_ff.value);
   assign mask     = 8'b1 << cmd_ff.button_slot;

   always_comb begin
      desc        = '0;
      desc.status = ST_OK;
      desc.b1     = OP_SET;
      cs_sel      = CS_AT_16;
      en          = 8'd0;
      case (cmd_ff.mode)
         MODE_RES: begin
            if (!in_range_ff || (quot_x50 != {1'b0, cmd_ff.value[13:0]})) begin
               desc.is_err = 1'b1;
               desc.status = ST_BAD_VALUE;
            end
            desc.b4  = RES_SUBHDR;
            desc.b5  = LEN_FOUR;
            desc.b6  = 8'(quot_ff - 1'b1);
            desc.b7  = 8'(quot_ff - 1'b1);
            desc.b16 = RES_TRAILER;
            cs_sel   = CS_AT_9;
         end
         MODE_RATE: begin
            if (rate_raw == 8'd0) begin
               desc.is_err = 1'b1;
               desc.status = ST_BAD_VALUE;
            end
            desc.b5  = LEN_TWO;
            desc.b6  = rate_raw;
            desc.b16 = RATE_TRAILER;
            cs_sel   = CS_AT_7;
         end
         MODE_DEB: begin
            if (cmd_ff.value[15:8] != 8'd0) begin
               desc.is_err = 1'b1;
               desc.status = ST_BAD_VALUE;
            end
            desc.b4  = DEB_SUBHDR;
            desc.b5  = LEN_TWO;
            desc.b6  = cmd_ff.value[7:0];
            desc.b16 = DEB_TRAILER;
            cs_sel   = CS_AT_7;
         end
         MODE_BTN: begin
            if (cmd_ff.action_kind == KIND_DISABLE) begin
               en = 8'd0;
            end else if (cmd_ff.action_kind == KIND_BUTTON &&
                         cmd_ff.target_button >= 4'd1 && cmd_ff.target_button <= 4'd5) begin
               en      = 8'd1;
               desc.b4 = button_code(cmd_ff.target_button);
            end else begin
               desc.is_err = 1'b1;
               desc.status = ST_BAD_ACTION;
            end
            desc.b5 = LEN_FOUR;
            desc.b6 = en;
            desc.b7 = mask;
            desc.b9 = SUM_TARGET - en - mask;
            cs_sel  = CS_AT_16;
         end
         MODE_COMMIT: begin
            desc.b1 = OP_COMMIT;
            desc.b5 = LEN_ONE;
            cs_sel  = CS_AT_16;
         end
         MODE_FW: begin
            desc.b1 = OP_FW;
            desc.b5 = LEN_EIGHT;
            cs_sel  = CS_AT_16;
         end
         default: begin
            desc.is_err = 1'b1;
            desc.status = ST_BAD_VALUE;
         end
      endcase

      // The checksum slot is still zero here, so the plain sum of all bytes serves.
      byte_sum = FRAME_TAG + desc.b1 + desc.b4 + desc.b5 + desc.b6 + desc.b7
                 + desc.b9 + desc.b16;
      cs = SUM_TARGET - byte_sum;
      case (cs_sel)
         CS_AT_7:  desc.b7  = cs;
         CS_AT_9:  desc.b9  = cs;
         default:  desc.b16 = cs;
      endcase
   end

   assign desc_valid = valid_ff;
   assign desc_data  = desc;

endmodule
`default_nettype wire

// File: rtl/mcf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_queue
// Short descriptor queue between the classifying front and the serialiser.
// ----------------------------------------------------------------------------
module mcf_queue #(
   parameter int DEPTH = 2
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  mcf_pkg::mcf_desc_type wr_data,
   output logic                  full,
   input  wire                   rd_en,
   output mcf_pkg::mcf_desc_type rd_data,
   output logic                  empty
);
   import mcf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mcf_desc_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above its depth");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (wr_en && full) |=> wr_en)
      else $error("front withdrew a transaction refused by a full queue");

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("serialiser popped an empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue occupancy lost a write");
`endif

endmodule
`default_nettype wire

// File: rtl/mcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcf_back
// Serialises one descriptor into report bytes through an output register.
// ----------------------------------------------------------------------------
module mcf_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   head_empty,
   input  mcf_pkg::mcf_desc_type head_data,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  wire                   rsp_pop,
   output mcf_pkg::mcf_rsp_type  rsp_data
);
   import mcf_pkg::*;

   localparam logic [IDX_W-1:0] POS_OPCODE = IDX_W'(1);
   localparam logic [IDX_W-1:0] POS_B4     = IDX_W'(4);
   localparam logic [IDX_W-1:0] POS_B5     = IDX_W'(5);
   localparam logic [IDX_W-1:0] POS_B6     = IDX_W'(6);
   localparam logic [IDX_W-1:0] POS_B7     = IDX_W'(7);
   localparam logic [IDX_W-1:0] POS_B9     = IDX_W'(9);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   mcf_rsp_type      out_ff, out_in;
   logic             load;
   logic [7:0]       cur_byte;

   assign load     = !head_empty && (!out_valid_ff || rsp_pop);
   assign head_pop = load && out_in.last_byte;

   always_comb begin
      case (idx_ff)
         '0:         cur_byte = FRAME_TAG;
         POS_OPCODE: cur_byte = head_data.b1;
         POS_B4:     cur_byte = head_data.b4;
         POS_B5:     cur_byte = head_data.b5;
         POS_B6:     cur_byte = head_data.b6;
         POS_B7:     cur_byte = head_data.b7;
         POS_B9:     cur_byte = head_data.b9;
         LAST_IDX:   cur_byte = head_data.b16;
         default:    cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      // A rejected command is a single zero byte carrying its status.
      if (head_data.is_err) begin
         out_in.packet_byte = 8'h00;
         out_in.last_byte   = 1'b1;
         out_in.status      = head_data.status;
      end else begin
         out_in.packet_byte = cur_byte;
         out_in.last_byte   = (idx_ff == LAST_IDX);
         out_in.status      = ST_OK;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = out_in.last_byte ? '0 : idx_ff + 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("byte index ran past the end of the report");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (idx_ff == '0))
      else $error("byte index not rewound after the final byte");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (load && head_data.is_err) |-> (idx_ff == '0))
      else $error("error transaction met part way through a report");
`endif

endmodule
`default_nettype wire

// File: rtl/mouse_config_command_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_config_command_framer
// Turns mouse configuration commands into serialised 17-byte output reports.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter as queue pushes: a transaction completes on a rising edge
//   with req_push high and req_full low. Result bytes leave the same way:
//   rsp_data holds the oldest byte while rsp_empty is low, and it is taken on
//   an edge with rsp_pop high.
//   A valid command yields 17 bytes, the last flagged by last_byte; a rejected
//   command yields one zero byte with last_byte set and a non-zero status.
//   The first byte of a report passes the front register, a queue entry and
//   the output register. The serialiser gives one byte per cycle while rsp_pop
//   is held high and the queue holds a descriptor.
//   The front validates and checksums the next command while the serialiser
//   is busy; up to QUEUE_DEPTH classified commands wait between them, plus
//   one in the front register.
//   When rsp_pop is held low the output register holds its byte, the queue
//   fills and req_full rises; nothing is dropped.
//   Synchronous reset empties the pipeline; no configuration is kept.
// ----------------------------------------------------------------------------
module mouse_config_command_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  mcf_pkg::mcf_req_type req_data,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output mcf_pkg::mcf_rsp_type rsp_data
);
   import mcf_pkg::*;

   logic         desc_valid;
   logic         desc_full;
   mcf_desc_type desc_data;
   logic         head_empty;
   logic         head_pop;
   mcf_desc_type head_data;

   mcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .desc_valid (desc_valid),
      .desc_full  (desc_full),
      .desc_data  (desc_data)
   );

   mcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (desc_valid),
      .wr_data (desc_data),
      .full    (desc_full),
      .rd_en   (head_pop),
      .rd_data (head_data),
      .empty   (head_empty)
   );

   mcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_empty (head_empty),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
